### rtl/tars_pkg.sv
// shared constants, register codes and types of the tensor axis reduce-sum block
package tars_pkg;

    localparam int ELEM_W     = 32;
    localparam int OUT_IDX_W  = 10;
    localparam int CFG_DIMS   = 4;
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int AXIS_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int ACC_DEPTH_DEF  = 1024;
    localparam int MAX_RANK_DEF   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_SIZE_0 = 3'd0,
        CFG_DIM_SIZE_1 = 3'd1,
        CFG_DIM_SIZE_2 = 3'd2,
        CFG_DIM_SIZE_3 = 3'd3,
        CFG_AXIS_MASK  = 3'd4
    } t_cfg_reg;

    // effective sizes and reduced-dimension set
    typedef struct packed {
        logic [CFG_DIMS-1:0][DIM_W-1:0] size;
        logic [CFG_DIMS-1:0]            red;
    } t_cfg_view;

    // where the element sits with respect to its output
    typedef struct packed {
        logic first;
        logic done;
        logic last;
    } t_pos;

    typedef struct packed {
        logic signed [ELEM_W-1:0] x;
        t_pos                     pos;
        logic [OUT_IDX_W-1:0]     lo;
    } t_item;

endpackage

### rtl/tars_if.sv
// handshake channels: element input, result output and register writes
interface tars_in_if;
    import tars_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element_value;
    modport source(output valid, output element_value, input ready);
    modport sink(input valid, input element_value, output ready);
endinterface

interface tars_out_if;
    import tars_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] sum_value;
    logic [OUT_IDX_W-1:0]     out_index;
    logic                     last_out;
    logic                     overflow_flag;
    modport source(output valid, output sum_value, output out_index, output last_out,
                   output overflow_flag, input ready);
    modport sink(input valid, input sum_value, input out_index, input last_out,
                 input overflow_flag, output ready);
endinterface

interface tars_cfg_if;
    import tars_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/tensor_axis_reduce_sum.sv
// Streaming sum of a tensor of up to four dimensions over the axes selected by axis_mask.
// Elements enter one per item in row-major order and the block takes one element every
// clock while the result register is free or being drained; a stalled result holds the
// whole pipeline. An element is latched with its coordinate flags at the edge that takes
// it, then passes one multiply-add stage per dimension to form the output index, the
// accumulator memory read, and the add and write-back, and then reaches the result
// register. The memory has one read and one write port; an add into the entry written
// by the element just ahead is forwarded, so back-to-back elements of the same output
// never wait. A sum starts at the first element of its output and is sent at the last
// one; an output whose index is at or beyond ACC_DEPTH is neither read nor written and
// comes out with overflow_flag set and a zero sum. The memory needs no clearing pass
// after reset. Write the registers only while the block is idle.
module tensor_axis_reduce_sum #(
    parameter int DATA_WIDTH = tars_pkg::DATA_WIDTH_DEF,
    parameter int ACC_DEPTH  = tars_pkg::ACC_DEPTH_DEF,
    parameter int MAX_RANK   = tars_pkg::MAX_RANK_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tars_in_if.sink    i_in,
    tars_out_if.source o_out,
    tars_cfg_if.sink   i_cfg
);
    import tars_pkg::*;

    localparam int NDIM   = (MAX_RANK < CFG_DIMS) ? MAX_RANK : CFG_DIMS;
    localparam int ADDR_W = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

    t_cfg_view                    view;
    t_pos                         pos;
    logic [NDIM-1:0][COORD_W-1:0] cl;
    logic                         adv;
    logic                         accept;
    logic                         rd_vld;
    t_item                        rd_item;
    logic                         rd_inside;
    logic [ADDR_W-1:0]            rd_addr;

    assign i_in.ready = adv;
    assign accept     = i_in.valid && adv;

    tars_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_view  (view)
    );

    tars_coord #(
        .NDIM (NDIM)
    ) u_coord (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_view   (view),
        .o_pos    (pos),
        .o_cl     (cl)
    );

    tars_index #(
        .NDIM      (NDIM),
        .ACC_DEPTH (ACC_DEPTH)
    ) u_index (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_accept (accept),
        .i_x      (i_in.element_value),
        .i_pos    (pos),
        .i_cl     (cl),
        .i_view   (view),
        .o_vld    (rd_vld),
        .o_item   (rd_item),
        .o_inside (rd_inside),
        .o_addr   (rd_addr)
    );

    tars_accum #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_DEPTH  (ACC_DEPTH)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_vld    (rd_vld),
        .i_rd_item   (rd_item),
        .i_rd_inside (rd_inside),
        .i_rd_addr   (rd_addr),
        .o_adv       (adv),
        .o_out       (o_out)
    );

endmodule

### rtl/tars_cfg.sv
// configuration registers with size clamping and reduce-set decode
module tars_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tars_cfg_if.sink            i_cfg,
    output tars_pkg::t_cfg_view o_view
);
    import tars_pkg::*;

    logic [CFG_DIMS-1:0][DIM_W-1:0] r_dim;
    logic [AXIS_W-1:0]              r_axis;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_DIMS; k++) begin
                r_dim[k] <= DIM_W'(1);
            end
            r_axis <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DIM_SIZE_0: r_dim[0] <= i_cfg.data;
                CFG_DIM_SIZE_1: r_dim[1] <= i_cfg.data;
                CFG_DIM_SIZE_2: r_dim[2] <= i_cfg.data;
                CFG_DIM_SIZE_3: r_dim[3] <= i_cfg.data;
                CFG_AXIS_MASK:  r_axis   <= i_cfg.data[AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < CFG_DIMS; k++) begin
            if (r_dim[k] == '0) begin
                o_view.size[k] = DIM_W'(1);
            end else if (r_dim[k] > MAX_DIM) begin
                o_view.size[k] = MAX_DIM;
            end else begin
                o_view.size[k] = r_dim[k];
            end
        end
        // empty mask reduces everything
        o_view.red = (r_axis == '0) ? '1 : r_axis;
    end

endmodule

### rtl/tars_coord.sv
// coordinate counters: position flags, clamped coordinates and row-major advance
module tars_coord #(
    parameter int NDIM = tars_pkg::CFG_DIMS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  tars_pkg::t_cfg_view                   i_view,
    output tars_pkg::t_pos                        o_pos,
    output logic [NDIM-1:0][tars_pkg::COORD_W-1:0] o_cl
);
    import tars_pkg::*;

    logic [NDIM-1:0][COORD_W-1:0] r_coord;
    logic [NDIM-1:0][COORD_W-1:0] n_coord;
    logic [NDIM-1:0][COORD_W-1:0] lim;
    logic [NDIM-1:0]              at_last;
    logic [NDIM-1:0]              carry;
    logic                         run;

    always_comb begin
        o_pos.first = 1'b1;
        o_pos.done  = 1'b1;
        o_pos.last  = 1'b1;
        for (int k = 0; k < NDIM; k++) begin
            lim[k]     = COORD_W'(i_view.size[k] - 1'b1);
            at_last[k] = r_coord[k] >= lim[k];
            o_cl[k]    = at_last[k] ? lim[k] : r_coord[k];
            if (i_view.red[k]) begin
                if (r_coord[k] != '0) begin
                    o_pos.first = 1'b0;
                end
                if (!at_last[k]) begin
                    o_pos.done = 1'b0;
                end
            end
            if (!at_last[k]) begin
                o_pos.last = 1'b0;
            end
        end
        // innermost dimension always steps, carry ripples outward
        run = 1'b1;
        for (int k = NDIM - 1; k >= 0; k--) begin
            carry[k] = run;
            run      = run & at_last[k];
        end
        for (int k = 0; k < NDIM; k++) begin
            if (carry[k]) begin
                n_coord[k] = at_last[k] ? '0 : r_coord[k] + 1'b1;
            end else begin
                n_coord[k] = r_coord[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= '0;
        end else if (i_accept) begin
            r_coord <= n_coord;
        end
    end

endmodule

### rtl/tars_index.sv
// output index pipeline: one multiply-add per kept dimension and stage
module tars_index #(
    parameter int NDIM      = tars_pkg::CFG_DIMS,
    parameter int ACC_DEPTH = tars_pkg::ACC_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  logic                                   i_accept,
    input  logic signed [tars_pkg::ELEM_W-1:0]     i_x,
    input  tars_pkg::t_pos                         i_pos,
    input  logic [NDIM-1:0][tars_pkg::COORD_W-1:0] i_cl,
    input  tars_pkg::t_cfg_view                    i_view,
    output logic                                   o_vld,
    output tars_pkg::t_item                        o_item,
    output logic                                   o_inside,
    output logic [((ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1)-1:0] o_addr
);
    import tars_pkg::*;

    localparam int ADDR_W = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    // saturating index: value ACC_DEPTH stands for anything at or beyond the depth
    localparam int SAT_W  = $clog2(ACC_DEPTH + 1);
    localparam int PL_W   = OUT_IDX_W + DIM_W + 1;
    localparam int PS_W   = SAT_W + DIM_W + 1;
    localparam logic [SAT_W-1:0] SAT_TOP = SAT_W'(ACC_DEPTH);

    logic                         r_vld  [NDIM+1];
    t_item                        r_item [NDIM+1];
    logic [NDIM-1:0][COORD_W-1:0] r_cl   [NDIM+1];
    logic [SAT_W-1:0]             r_sat  [NDIM+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item[0].x   <= i_x;
            r_item[0].pos <= i_pos;
            r_item[0].lo  <= '0;
            r_cl[0]       <= i_cl;
            r_sat[0]      <= '0;
        end
    end

    for (genvar k = 0; k < NDIM; k++) begin : g_stage
        logic [PL_W-1:0]  prod_lo;
        logic [PS_W-1:0]  prod_sat;
        logic [SAT_W-1:0] n_sat;
        t_item            n_item;

        always_comb begin
            prod_lo  = PL_W'(r_item[k].lo) * PL_W'(i_view.size[k]) + PL_W'(r_cl[k][k]);
            prod_sat = PS_W'(r_sat[k]) * PS_W'(i_view.size[k]) + PS_W'(r_cl[k][k]);
            n_item   = r_item[k];
            n_sat    = r_sat[k];
            if (!i_view.red[k]) begin
                n_item.lo = prod_lo[OUT_IDX_W-1:0];
                if (r_sat[k] == SAT_TOP || prod_sat >= PS_W'(ACC_DEPTH)) begin
                    n_sat = SAT_TOP;
                end else begin
                    n_sat = prod_sat[SAT_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_item[k+1] <= n_item;
                r_cl[k+1]   <= r_cl[k];
                r_sat[k+1]  <= n_sat;
            end
        end
    end

    assign o_vld    = r_vld[NDIM];
    assign o_item   = r_item[NDIM];
    assign o_inside = r_sat[NDIM] != SAT_TOP;
    assign o_addr   = o_inside ? ADDR_W'(r_sat[NDIM]) : '0;

endmodule

### rtl/tars_accum.sv
// accumulator memory with read-modify-write, write-to-read forwarding and output register
module tars_accum #(
    parameter int DATA_WIDTH = tars_pkg::DATA_WIDTH_DEF,
    parameter int ACC_DEPTH  = tars_pkg::ACC_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_vld,
    input  tars_pkg::t_item i_rd_item,
    input  logic            i_rd_inside,
    input  logic [((ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1)-1:0] i_rd_addr,
    output logic            o_adv,
    tars_out_if.source      o_out
);
    import tars_pkg::*;

    localparam int ADDR_W = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

    logic signed [DATA_WIDTH-1:0] r_mem [ACC_DEPTH];

    logic signed [DATA_WIDTH-1:0] r_rdata;
    logic                         r_w_vld;
    t_item                        r_w_item;
    logic                         r_w_inside;
    logic [ADDR_W-1:0]            r_w_addr;
    logic                         r_fwd;
    logic signed [DATA_WIDTH-1:0] r_fwd_sum;
    logic                         r_out_vld;
    logic signed [ELEM_W-1:0]     r_out_sum;
    logic [OUT_IDX_W-1:0]         r_out_idx;
    logic                         r_out_last;
    logic                         r_out_ovf;

    logic signed [DATA_WIDTH-1:0] w_x;
    logic signed [DATA_WIDTH-1:0] w_opnd;
    logic signed [DATA_WIDTH-1:0] w_sum;
    logic                         wr_en;
    logic                         emit;

    assign o_adv = !r_out_vld || o_out.ready;

    always_comb begin
        w_x    = DATA_WIDTH'(r_w_item.x);
        // the item just ahead wrote this entry on the edge of our read
        w_opnd = r_fwd ? r_fwd_sum : r_rdata;
        w_sum  = r_w_item.pos.first ? w_x : w_opnd + w_x;
        wr_en  = o_adv && r_w_vld && r_w_inside;
        emit   = r_w_vld && r_w_item.pos.done;
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_rd_vld && i_rd_inside) begin
            r_rdata <= r_mem[i_rd_addr];
        end
        if (wr_en) begin
            r_mem[r_w_addr] <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld   <= 1'b0;
            r_fwd     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            r_w_vld   <= i_rd_vld;
            r_fwd     <= i_rd_vld && i_rd_inside && r_w_vld && r_w_inside
                         && (i_rd_addr == r_w_addr);
            r_out_vld <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_w_item   <= i_rd_item;
            r_w_inside <= i_rd_inside;
            r_w_addr   <= i_rd_addr;
            r_fwd_sum  <= w_sum;
            if (emit) begin
                r_out_sum  <= r_w_inside ? ELEM_W'(w_sum) : '0;
                r_out_idx  <= r_w_item.lo;
                r_out_last <= r_w_item.pos.last;
                r_out_ovf  <= !r_w_inside;
            end
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.sum_value     = r_out_sum;
    assign o_out.out_index     = r_out_idx;
    assign o_out.last_out      = r_out_last;
    assign o_out.overflow_flag = r_out_ovf;

endmodule

### rtl/tars_chk.sv
// port-level checks for the reduce-sum block and their binding to the top level
module tars_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [tars_pkg::ELEM_W-1:0] i_out_sum,
    input logic [tars_pkg::OUT_IDX_W-1:0]     i_out_index,
    input logic                               i_out_last,
    input logic                               i_out_ovf
);
    import tars_pkg::*;

    // a waiting result keeps its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sum)
            && $stable(i_out_index) && $stable(i_out_last) && $stable(i_out_ovf))
        else $error("result changed while stalled");

    // an output beyond the accumulator carries no sum
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ovf |-> i_out_sum == '0)
        else $error("overflowed output with nonzero sum");

    // a stalled result holds back the input side
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("element taken while result stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind tensor_axis_reduce_sum tars_chk u_tars_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_sum   (o_out.sum_value),
    .i_out_index (o_out.out_index),
    .i_out_last  (o_out.last_out),
    .i_out_ovf   (o_out.overflow_flag)
);

### tb/sv/tars_checker.sv
// checker for the tensor reduce-sum block: predicts the sums from the observed items and compares
module tars_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tars_in_if   i_in,
    tars_out_if  i_out,
    tars_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import tars_pkg::*;

    localparam int ACC_DEPTH = ACC_DEPTH_DEF;

    typedef struct packed {
        logic signed [ELEM_W-1:0] sum;
        logic [OUT_IDX_W-1:0]     index;
        logic                     last;
        logic                     ovf;
    } t_reduced_out;

    logic [DIM_W-1:0]   dim_reg [CFG_DIMS];
    logic [AXIS_W-1:0]  axis_sel;
    logic [COORD_W-1:0] coord [CFG_DIMS];
    logic [ELEM_W-1:0]  acc_mem [ACC_DEPTH];
    t_reduced_out       reduced_q [$];

    function automatic logic [DIM_W-1:0] eff_size(input int k);
        logic [DIM_W-1:0] s;
        s = dim_reg[k];
        if (s == '0) begin
            s = DIM_W'(1);
        end
        if (s > MAX_DIM) begin
            s = MAX_DIM;
        end
        return s;
    endfunction

    // one element: update the partial sum and queue a finished sum if this element closes it
    task automatic accumulate_element(input logic [ELEM_W-1:0] x);
        logic [AXIS_W-1:0] red;
        logic [63:0]       idx;
        logic [DIM_W-1:0]  s;
        logic [DIM_W-1:0]  c;
        logic              at_last;
        logic              first;
        logic              done;
        logic              final_el;
        logic              in_depth;
        logic [ELEM_W-1:0] sum;
        t_reduced_out      r;
        int                k;
        red      = (axis_sel != '0) ? axis_sel : '1;
        idx      = '0;
        first    = 1'b1;
        done     = 1'b1;
        final_el = 1'b1;
        for (k = 0; k < CFG_DIMS; k++) begin
            s       = eff_size(k);
            c       = {1'b0, coord[k]};
            at_last = (c >= s - 1);
            if (red[k]) begin
                if (c != '0) begin
                    first = 1'b0;
                end
                if (!at_last) begin
                    done = 1'b0;
                end
            end else begin
                // coordinates past a shrunk size clamp to the last position
                idx = idx * s + (at_last ? s - 1 : c);
            end
            if (!at_last) begin
                final_el = 1'b0;
            end
        end
        in_depth = (idx < ACC_DEPTH);
        sum      = '0;
        if (in_depth) begin
            sum = first ? x : acc_mem[idx[OUT_IDX_W-1:0]] + x;
            acc_mem[idx[OUT_IDX_W-1:0]] = sum;
        end
        for (k = CFG_DIMS - 1; k >= 0; k--) begin
            s = eff_size(k);
            if ({1'b0, coord[k]} >= s - 1) begin
                coord[k] = '0;
            end else begin
                coord[k] = coord[k] + 1'b1;
                break;
            end
        end
        if (done) begin
            r.sum     = sum;
            r.index   = idx[OUT_IDX_W-1:0];
            r.last    = final_el;
            r.ovf     = !in_depth;
            reduced_q = {reduced_q, r};
        end
    endtask

    always @(posedge i_clk) begin
        t_reduced_out want;
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_DIMS; k++) begin
                dim_reg[k] = DIM_W'(1);
                coord[k]   = '0;
            end
            for (int a = 0; a < ACC_DEPTH; a++) begin
                acc_mem[a] = '0;
            end
            axis_sel = '0;
            reduced_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (reduced_q.size() == 0) begin
                    $display("%0t: unexpected sum: sum_value %0d out_index %0d last %0b ovf %0b",
                             $time, $signed(i_out.sum_value), i_out.out_index, i_out.last_out,
                             i_out.overflow_flag);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = reduced_q.pop_front();
                    if (i_out.sum_value !== want.sum) begin
                        $display("%0t: sum_value expected %0d actual %0d", $time,
                                 $signed(want.sum), $signed(i_out.sum_value));
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out.out_index !== want.index) begin
                        $display("%0t: out_index expected %0d actual %0d", $time,
                                 want.index, i_out.out_index);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out.last_out !== want.last) begin
                        $display("%0t: last_out expected %0b actual %0b", $time,
                                 want.last, i_out.last_out);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out.overflow_flag !== want.ovf) begin
                        $display("%0t: overflow_flag expected %0b actual %0b", $time,
                                 want.ovf, i_out.overflow_flag);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_reg'(i_cfg.index))
                    CFG_DIM_SIZE_0: dim_reg[0] = i_cfg.data[DIM_W-1:0];
                    CFG_DIM_SIZE_1: dim_reg[1] = i_cfg.data[DIM_W-1:0];
                    CFG_DIM_SIZE_2: dim_reg[2] = i_cfg.data[DIM_W-1:0];
                    CFG_DIM_SIZE_3: dim_reg[3] = i_cfg.data[DIM_W-1:0];
                    CFG_AXIS_MASK:  axis_sel   = i_cfg.data[AXIS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                accumulate_element(i_in.element_value);
            end
        end
        o_pending = reduced_q.size();
    end

endmodule

### tb/sv/tb_top.sv
// testbench top for the tensor reduce-sum block: clock, reset, stimulus and verdict
module tb_top;
    import tars_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int FLUSH_CYCLES = 16;
    localparam int LIMIT_CYCLES = 3000000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   end_count;
    bit   quiet;

    tars_in_if  in_if ();
    tars_out_if out_if ();
    tars_cfg_if cfg_if ();

    tensor_axis_reduce_sum DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    tars_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .i_out       (out_if),
        .i_cfg       (cfg_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    // tensor ends seen on the output, used to close an interrupted tensor
    initial begin
        end_count = 0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready && out_if.last_out) begin
                end_count <= end_count + 1;
            end
        end
    end

    // output back-pressure
    initial begin
        int stall;
        int pick;
        out_if.ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else if (quiet) begin
                out_if.ready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    out_if.ready <= 1'b1;
                end else begin
                    stall = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                    out_if.ready <= 1'b0;
                    stall--;
                end
            end
        end
    end

    function automatic int rand_gap();
        int pick;
        if (quiet) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ELEM_W-1:0] rand_element();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int eff_dim(input int d);
        if (d == 0) begin
            return 1;
        end
        return (d > 4096) ? 4096 : d;
    endfunction

    task automatic send_element(input logic [ELEM_W-1:0] v, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.element_value <= v;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic send_tensor(input int n);
        repeat (n) send_element(rand_element(), rand_gap());
    endtask

    // hold off until every sum is out and the pipeline has flushed
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (FLUSH_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg r, input logic [CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= r;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_shape(input int d0, input int d1, input int d2, input int d3,
                             input logic [AXIS_W-1:0] mask);
        write_reg(CFG_DIM_SIZE_0, CFG_DATA_W'(d0));
        write_reg(CFG_DIM_SIZE_1, CFG_DATA_W'(d1));
        write_reg(CFG_DIM_SIZE_2, CFG_DATA_W'(d2));
        write_reg(CFG_DIM_SIZE_3, CFG_DATA_W'(d3));
        write_reg(CFG_AXIS_MASK, CFG_DATA_W'(mask));
    endtask

    // reshape an interrupted tensor to a full reduction and run it out
    task automatic close_tensor(output int sent);
        int mark;
        set_shape($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                  $urandom_range(0, 3), 4'b0000);
        mark = end_count;
        sent = 0;
        while (end_count == mark) begin
            send_element(rand_element(), 0);
            sent++;
            drain();
        end
    endtask

    initial begin
        int               dims [CFG_DIMS];
        int               n;
        int               cut;
        int               sent;
        int               rand_count;
        logic [AXIS_W-1:0] mask;
        in_if.valid         = 1'b0;
        in_if.element_value = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        quiet               = 1'b0;
        rand_count          = 0;
        i_rst_n             = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // scalar with reset sizes: each sum is the element itself
        send_element(32'h7FFF_FFFF, 0);
        send_element(32'h8000_0000, 0);
        send_element(32'h0000_0000, 1);
        send_element(32'hFFFF_FFFF, 0);
        drain();
        // full reduction that wraps
        set_shape(1, 1, 2, 2, 4'b0000);
        repeat (4) send_element(32'h7FFF_FFFF, 0);
        drain();
        // zero sizes act as one, innermost axis reduced
        set_shape(0, 0, 2, 3, 4'b1000);
        repeat (3) send_element(32'h8000_0000, 0);
        send_element(32'h0000_0001, 2);
        send_element(32'hFFFF_FFFF, 0);
        send_element(32'h8000_0000, 0);
        drain();
        // outer axis reduced: sums close in the second half
        set_shape(2, 1, 1, 3, 4'b0001);
        send_tensor(6);
        drain();

        // output index runs past the accumulator depth and wraps in the index field
        set_shape(1, 1, 1, 1040, 4'b0001);
        send_tensor(1040);
        drain();
        // size above the maximum counts as 4096: a few outputs, then close the tensor
        set_shape(1, 1, 1, 4097, 4'b0001);
        send_tensor(8);
        drain();
        close_tensor(sent);
        drain();

        while (rand_count < RANDOM_ITEMS) begin
            for (int k = 0; k < CFG_DIMS; k++) begin
                dims[k] = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
            end
            if ($urandom_range(0, 3) == 0) begin
                dims[$urandom_range(0, CFG_DIMS - 1)] = $urandom_range(6, 20);
            end
            mask = AXIS_W'($urandom_range(0, 15));
            set_shape(dims[0], dims[1], dims[2], dims[3], mask);
            quiet = ($urandom_range(0, 3) == 0);
            n = eff_dim(dims[0]) * eff_dim(dims[1]) * eff_dim(dims[2]) * eff_dim(dims[3]);
            repeat ($urandom_range(1, 3)) begin
                send_tensor(n);
                rand_count += n;
                if ($urandom_range(0, 4) == 0) begin
                    drain();
                end
            end
            // interrupted tensor: reshape mid-way to a full reduction and run it out
            if (n > 1 && $urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, n - 1);
                send_tensor(cut);
                rand_count += cut;
                drain();
                close_tensor(sent);
                rand_count += sent;
            end
            drain();
        end

        quiet = 1'b0;
        drain();
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
